// ----- rtl/core/tscc_pkg.sv -----
// Shared types and constants for the three-stage charge controller.
// Used by every module in rtl/core; depends on nothing.
package tscc_pkg;

	localparam int VOLT_W = 15;
	localparam int CURR_W = 15;
	localparam int TICK_W = 16;
	localparam int HOLD_W = 8;
	localparam int TAPER_W = 5;
	localparam int CNT_W = 8;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam int CURRENT_MODE_HOLD = 10;
	localparam logic signed [HOLD_W-1:0] HOLD_CEIL = HOLD_W'(10);
	localparam logic signed [HOLD_W-1:0] HOLD_FLOOR = HOLD_W'(-CURRENT_MODE_HOLD);
	localparam logic [CNT_W-1:0] HOLD_COUNT = CNT_W'(CURRENT_MODE_HOLD);
	localparam logic [TAPER_W-1:0] TAPER_LIMIT = TAPER_W'(25);
	localparam logic [VOLT_W:0] FLOAT_EXIT_MARGIN = (VOLT_W+1)'(40);
	localparam logic [TICK_W-1:0] LOW_CURRENT_STEP = TICK_W'(2);
	localparam logic [TICK_W-1:0] LOW_CURRENT_TICKS_RST = TICK_W'(600);

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_MODE = 2'd1;
	localparam logic [1:0] REQ_STEP = 2'd2;

	localparam logic [2:0] REG_CUTOFF_VOLTAGE = 3'd0;
	localparam logic [2:0] REG_PRECHARGE_TICKS = 3'd1;
	localparam logic [2:0] REG_PRECHARGE_CURRENT = 3'd2;
	localparam logic [2:0] REG_CHARGE_VOLTAGE = 3'd3;
	localparam logic [2:0] REG_FLOAT_VOLTAGE = 3'd4;
	localparam logic [2:0] REG_CHARGE_CURRENT = 3'd5;
	localparam logic [2:0] REG_FLOAT_CURRENT = 3'd6;
	localparam logic [2:0] REG_LOW_CURRENT_TICKS = 3'd7;

	localparam logic [1:0] CODE_PRECHARGE = 2'd0;
	localparam logic [1:0] CODE_CHARGE = 2'd1;
	localparam logic [1:0] CODE_FLOAT = 2'd2;
	localparam logic [1:0] CODE_FAULT = 2'd3;

	typedef enum logic [3:0] {
		STG_PRECHARGE = 4'b0001,
		STG_CHARGE    = 4'b0010,
		STG_FLOAT     = 4'b0100,
		STG_FAULT     = 4'b1000
	} stage_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [VOLT_W-1:0] vsense;
		logic [CURR_W-1:0] isense;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        charge_stage;
		logic [VOLT_W-1:0] voltage_setpoint;
		logic [CURR_W-1:0] current_setpoint;
		logic              in_current_mode;
	} out_word_t;

	typedef struct packed {
		logic [VOLT_W-1:0] cutoff_level;
		logic [TICK_W-1:0] precharge_ticks;
		logic [CURR_W-1:0] precharge_current;
		logic [VOLT_W-1:0] charge_voltage;
		logic [VOLT_W-1:0] float_voltage;
		logic [CURR_W-1:0] charge_current;
		logic [CURR_W-1:0] float_current;
		logic [TICK_W-1:0] low_current_ticks;
	} cfg_t;

	typedef struct packed {
		stage_t                   stage;
		logic [TICK_W-1:0]        precharge_left;
		logic [TICK_W-1:0]        low_current_count;
		logic                     cc_mode;
		logic [CNT_W-1:0]         cv_hold_countdown;
		logic signed [HOLD_W-1:0] hold_level;
		logic [TAPER_W-1:0]       taper_tick;
		logic [VOLT_W-1:0]        vref;
		logic [CURR_W-1:0]        iref;
	} state_t;

	function automatic logic [1:0] stage_code(stage_t s);
		logic [1:0] c;
		case (s)
			STG_PRECHARGE: c = CODE_PRECHARGE;
			STG_CHARGE:    c = CODE_CHARGE;
			STG_FLOAT:     c = CODE_FLOAT;
			STG_FAULT:     c = CODE_FAULT;
			default:       c = CODE_PRECHARGE;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/tscc_cfg_regs.sv -----
// Configuration register file behind the APB-style port.
// Depends on tscc_pkg for the register indexes and the cfg_t struct.
module tscc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tscc_pkg::ADDR_W-1:0] paddr,
	input  logic [tscc_pkg::DATA_W-1:0] pwdata,
	output logic [tscc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output tscc_pkg::cfg_t             cfg
);

	tscc_pkg::cfg_t cfg_q;
	logic [2:0] idx;
	logic wr_en;

	assign idx = paddr[tscc_pkg::ADDR_W-1:2];
	assign wr_en = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cutoff_level <= '0;
			cfg_q.precharge_ticks <= '0;
			cfg_q.precharge_current <= '0;
			cfg_q.charge_voltage <= '0;
			cfg_q.float_voltage <= '0;
			cfg_q.charge_current <= '0;
			cfg_q.float_current <= '0;
			cfg_q.low_current_ticks <= tscc_pkg::LOW_CURRENT_TICKS_RST;
		end else if (wr_en) begin
			case (idx)
				tscc_pkg::REG_CUTOFF_VOLTAGE:
					cfg_q.cutoff_level <= pwdata[tscc_pkg::VOLT_W-1:0];
				tscc_pkg::REG_PRECHARGE_TICKS:
					cfg_q.precharge_ticks <= pwdata[tscc_pkg::TICK_W-1:0];
				tscc_pkg::REG_PRECHARGE_CURRENT:
					cfg_q.precharge_current <= pwdata[tscc_pkg::CURR_W-1:0];
				tscc_pkg::REG_CHARGE_VOLTAGE:
					cfg_q.charge_voltage <= pwdata[tscc_pkg::VOLT_W-1:0];
				tscc_pkg::REG_FLOAT_VOLTAGE:
					cfg_q.float_voltage <= pwdata[tscc_pkg::VOLT_W-1:0];
				tscc_pkg::REG_CHARGE_CURRENT:
					cfg_q.charge_current <= pwdata[tscc_pkg::CURR_W-1:0];
				tscc_pkg::REG_FLOAT_CURRENT:
					cfg_q.float_current <= pwdata[tscc_pkg::CURR_W-1:0];
				tscc_pkg::REG_LOW_CURRENT_TICKS:
					cfg_q.low_current_ticks <= pwdata[tscc_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			tscc_pkg::REG_CUTOFF_VOLTAGE:
				prdata = tscc_pkg::DATA_W'(cfg_q.cutoff_level);
			tscc_pkg::REG_PRECHARGE_TICKS:
				prdata = tscc_pkg::DATA_W'(cfg_q.precharge_ticks);
			tscc_pkg::REG_PRECHARGE_CURRENT:
				prdata = tscc_pkg::DATA_W'(cfg_q.precharge_current);
			tscc_pkg::REG_CHARGE_VOLTAGE:
				prdata = tscc_pkg::DATA_W'(cfg_q.charge_voltage);
			tscc_pkg::REG_FLOAT_VOLTAGE:
				prdata = tscc_pkg::DATA_W'(cfg_q.float_voltage);
			tscc_pkg::REG_CHARGE_CURRENT:
				prdata = tscc_pkg::DATA_W'(cfg_q.charge_current);
			tscc_pkg::REG_FLOAT_CURRENT:
				prdata = tscc_pkg::DATA_W'(cfg_q.float_current);
			tscc_pkg::REG_LOW_CURRENT_TICKS:
				prdata = tscc_pkg::DATA_W'(cfg_q.low_current_ticks);
			default: prdata = '0;
		endcase
	end

endmodule

// ----- rtl/core/tscc_update.sv -----
// Next-state logic for one request: start, CC/CV mode check or stage step.
// Depends on tscc_pkg for the state, configuration and word types.
module tscc_update (
	input  tscc_pkg::in_word_t item,
	input  tscc_pkg::cfg_t     cfg,
	input  tscc_pkg::state_t   cur,
	output tscc_pkg::state_t   nxt
);

	logic [tscc_pkg::TAPER_W-1:0] taper_inc;
	logic [tscc_pkg::TICK_W-1:0] lcc_dec;
	logic signed [tscc_pkg::HOLD_W-1:0] hold_dec;
	logic float_exit;
	tscc_pkg::state_t mode;

	assign taper_inc = cur.taper_tick + tscc_pkg::TAPER_W'(1);
	assign lcc_dec = (cur.low_current_count >= tscc_pkg::LOW_CURRENT_STEP) ?
		cur.low_current_count - tscc_pkg::LOW_CURRENT_STEP : '0;
	assign hold_dec = cur.hold_level - tscc_pkg::HOLD_W'(1);

	always_comb begin
		mode = cur;
		if (item.vsense > cur.vref) begin
			if (cur.hold_level < tscc_pkg::HOLD_CEIL)
				mode.hold_level = cur.hold_level + tscc_pkg::HOLD_W'(1);
			if (cur.cv_hold_countdown != '0)
				mode.cv_hold_countdown = cur.cv_hold_countdown - tscc_pkg::CNT_W'(1);
			else
				mode.cc_mode = 1'b0;
		end else begin
			mode.hold_level = hold_dec;
			if (hold_dec < tscc_pkg::HOLD_FLOOR) begin
				mode.cc_mode = 1'b1;
				mode.cv_hold_countdown = tscc_pkg::HOLD_COUNT;
				mode.hold_level = tscc_pkg::HOLD_FLOOR;
			end
		end
	end

	// The float exit needs the battery more than 40 counts below the float voltage.
	assign float_exit = (item.isense > cur.iref) && !mode.cc_mode &&
		(cur.stage == tscc_pkg::STG_FLOAT) &&
		(({1'b0, item.vsense} + tscc_pkg::FLOAT_EXIT_MARGIN) <
		{1'b0, cfg.float_voltage});

	always_comb begin
		nxt = cur;
		case (item.req_type)
			tscc_pkg::REQ_START: begin
				nxt.stage = tscc_pkg::STG_PRECHARGE;
				nxt.precharge_left = cfg.precharge_ticks;
				nxt.iref = cfg.precharge_current;
				nxt.vref = cfg.charge_voltage;
				nxt.low_current_count = cfg.low_current_ticks;
			end
			tscc_pkg::REQ_MODE: begin
				nxt = mode;
				if (float_exit) begin
					nxt.stage = tscc_pkg::STG_CHARGE;
					nxt.vref = cfg.charge_voltage;
					nxt.iref = cfg.charge_current;
					nxt.cc_mode = 1'b1;
					nxt.cv_hold_countdown = tscc_pkg::HOLD_COUNT;
				end
			end
			tscc_pkg::REQ_STEP: begin
				case (cur.stage)
					tscc_pkg::STG_PRECHARGE: begin
						if (item.vsense < cfg.cutoff_level) begin
							if (cur.precharge_left != '0)
								nxt.precharge_left =
									cur.precharge_left - tscc_pkg::TICK_W'(1);
							else
								nxt.stage = tscc_pkg::STG_FAULT;
						end else begin
							nxt.stage = tscc_pkg::STG_CHARGE;
							nxt.iref = cfg.charge_current;
						end
					end
					tscc_pkg::STG_CHARGE: begin
						if (!cur.cc_mode) begin
							if (item.isense < cfg.float_current) begin
								nxt.low_current_count = lcc_dec;
								if (lcc_dec < tscc_pkg::LOW_CURRENT_STEP)
									nxt.stage = tscc_pkg::STG_FLOAT;
							end else begin
								if (taper_inc > tscc_pkg::TAPER_LIMIT) begin
									nxt.taper_tick = '0;
									if (cur.vref > cfg.float_voltage)
										nxt.vref = cur.vref - tscc_pkg::VOLT_W'(1);
								end else begin
									nxt.taper_tick = taper_inc;
								end
								if (cur.low_current_count < cfg.low_current_ticks)
									nxt.low_current_count =
										cur.low_current_count + tscc_pkg::TICK_W'(1);
							end
						end
					end
					tscc_pkg::STG_FLOAT: begin
						nxt.vref = cfg.float_voltage;
						nxt.iref = cfg.float_current;
						nxt.cc_mode = 1'b0;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/three_stage_charge_controller.sv -----
// Top level of the three-stage charge controller: word pipeline and state.
// Depends on tscc_pkg, tscc_cfg_regs and tscc_update.
//
// Each input word is a start, a CC/CV mode check or a stage step, and gives one
// result word with the stage, the voltage and current setpoints and the mode.
// A word is registered on entry, updates the charge state as it advances out of
// that register and leaves from the output register; one word can be taken in
// every cycle unless the output stalls, a rate set by the one-word state update.
// The user must write configuration through the APB port while idle; unchecked.
module three_stage_charge_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  tscc_pkg::in_word_t          in_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output tscc_pkg::out_word_t         out_word,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tscc_pkg::ADDR_W-1:0] paddr,
	input  logic [tscc_pkg::DATA_W-1:0] pwdata,
	output logic [tscc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	tscc_pkg::cfg_t cfg;
	tscc_pkg::state_t state_q;
	tscc_pkg::state_t state_nxt;
	tscc_pkg::in_word_t word_s1;
	tscc_pkg::out_word_t word_s2;
	logic valid_s1;
	logic valid_s2;
	logic s2_blocked;
	logic advance;

	tscc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tscc_update u_update (
		.item (word_s1),
		.cfg  (cfg),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	assign s2_blocked = valid_s2 & out_stall;
	assign advance = valid_s1 & ~s2_blocked;
	assign in_stall = valid_s1 & s2_blocked;
	assign out_valid = valid_s2;
	assign out_word = word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q.stage <= tscc_pkg::STG_PRECHARGE;
			state_q.precharge_left <= '0;
			state_q.low_current_count <= '0;
			state_q.cc_mode <= 1'b0;
			state_q.cv_hold_countdown <= '0;
			state_q.hold_level <= '0;
			state_q.taper_tick <= '0;
			state_q.vref <= '0;
			state_q.iref <= '0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (!s2_blocked)
				valid_s2 <= valid_s1;
			if (advance)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			word_s1 <= in_word;
		if (advance) begin
			word_s2.charge_stage <= tscc_pkg::stage_code(state_nxt.stage);
			word_s2.voltage_setpoint <= state_nxt.vref;
			word_s2.current_setpoint <= state_nxt.iref;
			word_s2.in_current_mode <= state_nxt.cc_mode;
		end
	end

endmodule
